[rtl/ncp_pkg.sv]
// ----------------------------------------------------------------------------
// ncp_pkg
// Shared widths, controller states, datapath operations and the
// command/status structs for the rotation necklace counter.
// ----------------------------------------------------------------------------
package ncp_pkg;

  localparam int WORD_W = 32;
  localparam int MOD_W  = 16;
  localparam int IDX_W  = 17;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_J_TEST,
    ST_J_WAIT,
    ST_T_INIT,
    ST_TQ_TEST,
    ST_TQ_WAIT,
    ST_TS_WAIT,
    ST_TV_START,
    ST_TV_WAIT,
    ST_T_TAIL,
    ST_TT_WAIT,
    ST_F_START,
    ST_F_WAIT,
    ST_E_START,
    ST_E_WAIT,
    ST_B_START,
    ST_B_WAIT,
    ST_P_TEST,
    ST_PA_WAIT,
    ST_PB_START,
    ST_PB_WAIT,
    ST_M_START,
    ST_M_WAIT,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_NJ,
    OP_J_HIT,
    OP_J_NEXT,
    OP_D_J,
    OP_D_QJ,
    OP_T_INIT,
    OP_DIV_VQ,
    OP_DIV_SQ,
    OP_S_UPD_Q,
    OP_V_UPD,
    OP_Q_NEXT,
    OP_DIV_SV,
    OP_S_UPD_V,
    OP_DIV_SP,
    OP_F_SET,
    OP_DIV_ND,
    OP_E_SET,
    OP_DIV_NP,
    OP_B_SET,
    OP_DIV_AB,
    OP_A_SET,
    OP_DIV_BB,
    OP_B_SQ,
    OP_DIV_FA,
    OP_ANS_ADD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic trivial;
    logic j_lt;
    logic j_eq;
    logic q_stop;
    logic v_gt1;
    logic exp_zero;
    logic exp_odd;
  } sts_t;

endpackage

[rtl/ncp_ifs.sv]
// ----------------------------------------------------------------------------
// ncp_ifs
// Valid/ready channels for the necklace counter: request and result.
// ----------------------------------------------------------------------------
interface ncp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] necklace_length;
  logic [15:0] modulus;

  modport source (output valid, output necklace_length, output modulus, input ready);
  modport sink   (input valid, input necklace_length, input modulus, output ready);
endinterface

interface ncp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] count_mod_p;

  modport source (output valid, output count_mod_p, input ready);
  modport sink   (input valid, input count_mod_p, output ready);
endinterface

[rtl/ncp_div.sv]
// ----------------------------------------------------------------------------
// ncp_div
// Restoring divider, one quotient bit per cycle.
// Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module ncp_div
  import ncp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quot,
  output logic [WORD_W-1:0] rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dsr_r, dsr_nxt;
  logic [WORD_W:0]   rem_shift;
  logic              ge;

  // Shift in the next dividend bit and try to subtract
  assign rem_shift = {rem_r, quo_r[WORD_W-1]};
  assign ge        = rem_shift >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WORD_W-2:0], ge};
      rem_nxt = ge ? WORD_W'(rem_shift - {1'b0, dsr_r}) : rem_shift[WORD_W-1:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider not busy after start");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
`endif

endmodule

[rtl/ncp_datapath.sv]
// ----------------------------------------------------------------------------
// ncp_datapath
// Working registers for divisor scan, totient and modular power, plus the
// shared divider. Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module ncp_datapath
  import ncp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [WORD_W-1:0] in_n,
  input  logic [MOD_W-1:0]  in_p,
  output sts_t              sts,
  output logic [MOD_W-1:0]  ans
);

  logic [WORD_W-1:0] n_r, n_nxt;
  logic [MOD_W-1:0]  p_r, p_nxt;
  logic [MOD_W-1:0]  ans_r, ans_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [WORD_W-1:0] qj_r, qj_nxt;
  logic [WORD_W-1:0] d_r, d_nxt;
  logic [WORD_W-1:0] v_r, v_nxt;
  logic [WORD_W-1:0] s_r, s_nxt;
  logic [WORD_W-1:0] exp_r, exp_nxt;
  logic [MOD_W-1:0]  f_r, f_nxt;
  logic [MOD_W-1:0]  base_r, base_nxt;
  logic [MOD_W-1:0]  acc_r, acc_nxt;

  logic              div_start;
  logic [WORD_W-1:0] div_a, div_b;
  logic              div_done;
  logic [WORD_W-1:0] div_q, div_rem;

  logic [2*IDX_W-1:0]  jsq, qsq;
  logic [WORD_W-1:0]   s_mul;
  logic [MOD_W:0]      sum;

  ncp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // Loop bounds
  assign jsq = j_r * j_r;
  assign qsq = q_r * q_r;

  always_comb begin
    sts.div_done = div_done;
    sts.rem_zero = (div_rem == '0);
    sts.trivial  = (n_r == '0) || (p_r <= MOD_W'(1));
    sts.j_lt     = jsq < {2'b0, n_r};
    sts.j_eq     = jsq == {2'b0, n_r};
    sts.q_stop   = qsq > {2'b0, v_r};
    sts.v_gt1    = v_r > WORD_W'(1);
    sts.exp_zero = (exp_r == '0);
    sts.exp_odd  = exp_r[0];
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b1;
    div_a     = n_r;
    div_b     = {16'b0, p_r};
    case (cmd.op)
      OP_DIV_NJ: begin div_a = n_r; div_b = WORD_W'(j_r); end
      OP_DIV_VQ: begin div_a = v_r; div_b = WORD_W'(q_r); end
      OP_DIV_SQ: begin div_a = s_r; div_b = WORD_W'(q_r); end
      OP_DIV_SV: begin div_a = s_r; div_b = v_r; end
      OP_DIV_SP: div_a = s_r;
      OP_DIV_ND: begin div_a = n_r; div_b = d_r; end
      OP_DIV_NP: div_a = n_r;
      OP_DIV_AB: div_a = WORD_W'(acc_r) * WORD_W'(base_r);
      OP_DIV_BB: div_a = WORD_W'(base_r) * WORD_W'(base_r);
      OP_DIV_FA: div_a = WORD_W'(f_r) * WORD_W'(acc_r);
      default:   div_start = 1'b0;
    endcase
  end

  // Totient update multiply; s/q*(q-1) never exceeds s, so one word holds it
  always_comb begin
    if (cmd.op == OP_S_UPD_V) s_mul = div_q * (v_r - WORD_W'(1));
    else s_mul = div_q * WORD_W'(q_r - IDX_W'(1));
  end

  assign sum = {1'b0, ans_r} + {1'b0, div_rem[MOD_W-1:0]};

  // Register updates
  always_comb begin
    n_nxt = n_r; p_nxt = p_r; ans_nxt = ans_r; j_nxt = j_r; q_nxt = q_r;
    qj_nxt = qj_r; d_nxt = d_r; v_nxt = v_r; s_nxt = s_r; exp_nxt = exp_r;
    f_nxt = f_r; base_nxt = base_r; acc_nxt = acc_r;
    case (cmd.op)
      OP_LOAD: begin
        n_nxt = in_n; p_nxt = in_p; ans_nxt = '0; j_nxt = IDX_W'(1);
      end
      OP_J_HIT:   begin d_nxt = WORD_W'(j_r); qj_nxt = div_q; end
      OP_J_NEXT:  j_nxt = j_r + IDX_W'(1);
      OP_D_J:     d_nxt = WORD_W'(j_r);
      OP_D_QJ:    d_nxt = qj_r;
      OP_T_INIT:  begin v_nxt = d_r; s_nxt = d_r; q_nxt = IDX_W'(2); end
      OP_S_UPD_Q: s_nxt = s_mul;
      OP_S_UPD_V: s_nxt = s_mul;
      OP_V_UPD:   v_nxt = div_q;
      OP_Q_NEXT:  q_nxt = (q_r == IDX_W'(2)) ? IDX_W'(3) : q_r + IDX_W'(2);
      OP_F_SET:   f_nxt = div_rem[MOD_W-1:0];
      OP_E_SET:   exp_nxt = div_q - WORD_W'(1);
      OP_B_SET:   begin base_nxt = div_rem[MOD_W-1:0]; acc_nxt = MOD_W'(1); end
      OP_A_SET:   acc_nxt = div_rem[MOD_W-1:0];
      OP_B_SQ:    begin base_nxt = div_rem[MOD_W-1:0]; exp_nxt = exp_r >> 1; end
      OP_ANS_ADD: ans_nxt = (sum >= {1'b0, p_r}) ? MOD_W'(sum - {1'b0, p_r})
                                                 : sum[MOD_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ans_r <= '0;
      p_r   <= '0;
    end else begin
      ans_r <= ans_nxt;
      p_r   <= p_nxt;
    end
    n_r <= n_nxt; j_r <= j_nxt; q_r <= q_nxt; qj_r <= qj_nxt; d_r <= d_nxt;
    v_r <= v_nxt; s_r <= s_nxt; exp_r <= exp_nxt; f_r <= f_nxt;
    base_r <= base_nxt; acc_r <= acc_nxt;
  end

  assign ans = ans_r;

endmodule

[rtl/ncp_ctrl.sv]
// ----------------------------------------------------------------------------
// ncp_ctrl
// Sequencer: scans divisor pairs, runs the totient trial division and the
// modular power for each divisor, and hands the total to the output.
// ----------------------------------------------------------------------------
module ncp_ctrl
  import ncp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   second_r, second_nxt;

  // Next state
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    second_nxt = second_r;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = ST_CHECK;
        last_nxt  = 1'b0;
      end
      ST_CHECK: state_nxt = sts.trivial ? ST_DONE : ST_J_TEST;
      ST_J_TEST: begin
        if (sts.j_lt) state_nxt = ST_J_WAIT;
        else if (sts.j_eq) begin
          state_nxt = ST_T_INIT;
          last_nxt  = 1'b1;
        end else state_nxt = ST_DONE;
      end
      ST_J_WAIT: if (sts.div_done) begin
        if (sts.rem_zero) begin
          state_nxt  = ST_T_INIT;
          second_nxt = 1'b0;
        end else state_nxt = ST_J_TEST;
      end
      ST_T_INIT:  state_nxt = ST_TQ_TEST;
      ST_TQ_TEST: state_nxt = sts.q_stop ? ST_T_TAIL : ST_TQ_WAIT;
      ST_TQ_WAIT: if (sts.div_done) state_nxt = sts.rem_zero ? ST_TS_WAIT : ST_TQ_TEST;
      ST_TS_WAIT: if (sts.div_done) state_nxt = ST_TV_START;
      ST_TV_START: state_nxt = ST_TV_WAIT;
      ST_TV_WAIT: if (sts.div_done) state_nxt = sts.rem_zero ? ST_TV_START : ST_TQ_TEST;
      ST_T_TAIL:  state_nxt = sts.v_gt1 ? ST_TT_WAIT : ST_F_START;
      ST_TT_WAIT: if (sts.div_done) state_nxt = ST_F_START;
      ST_F_START: state_nxt = ST_F_WAIT;
      ST_F_WAIT:  if (sts.div_done) state_nxt = ST_E_START;
      ST_E_START: state_nxt = ST_E_WAIT;
      ST_E_WAIT:  if (sts.div_done) state_nxt = ST_B_START;
      ST_B_START: state_nxt = ST_B_WAIT;
      ST_B_WAIT:  if (sts.div_done) state_nxt = ST_P_TEST;
      ST_P_TEST: begin
        if (sts.exp_zero) state_nxt = ST_M_START;
        else if (sts.exp_odd) state_nxt = ST_PA_WAIT;
        else state_nxt = ST_PB_START;
      end
      ST_PA_WAIT:  if (sts.div_done) state_nxt = ST_PB_START;
      ST_PB_START: state_nxt = ST_PB_WAIT;
      ST_PB_WAIT:  if (sts.div_done) state_nxt = ST_P_TEST;
      ST_M_START:  state_nxt = ST_M_WAIT;
      ST_M_WAIT:   if (sts.div_done) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (last_r) state_nxt = ST_DONE;
        else if (!second_r) begin
          state_nxt  = ST_T_INIT;
          second_nxt = 1'b1;
        end else state_nxt = ST_J_TEST;
      end
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_J_TEST: begin
        if (sts.j_lt) cmd.op = OP_DIV_NJ;
        else if (sts.j_eq) cmd.op = OP_D_J;
      end
      ST_J_WAIT: if (sts.div_done) cmd.op = sts.rem_zero ? OP_J_HIT : OP_J_NEXT;
      ST_T_INIT:  cmd.op = OP_T_INIT;
      ST_TQ_TEST: if (!sts.q_stop) cmd.op = OP_DIV_VQ;
      ST_TQ_WAIT: if (sts.div_done) cmd.op = sts.rem_zero ? OP_DIV_SQ : OP_Q_NEXT;
      ST_TS_WAIT: if (sts.div_done) cmd.op = OP_S_UPD_Q;
      ST_TV_START: cmd.op = OP_DIV_VQ;
      ST_TV_WAIT: if (sts.div_done) cmd.op = sts.rem_zero ? OP_V_UPD : OP_Q_NEXT;
      ST_T_TAIL:  if (sts.v_gt1) cmd.op = OP_DIV_SV;
      ST_TT_WAIT: if (sts.div_done) cmd.op = OP_S_UPD_V;
      ST_F_START: cmd.op = OP_DIV_SP;
      ST_F_WAIT:  if (sts.div_done) cmd.op = OP_F_SET;
      ST_E_START: cmd.op = OP_DIV_ND;
      ST_E_WAIT:  if (sts.div_done) cmd.op = OP_E_SET;
      ST_B_START: cmd.op = OP_DIV_NP;
      ST_B_WAIT:  if (sts.div_done) cmd.op = OP_B_SET;
      ST_P_TEST:  if (!sts.exp_zero && sts.exp_odd) cmd.op = OP_DIV_AB;
      ST_PA_WAIT: if (sts.div_done) cmd.op = OP_A_SET;
      ST_PB_START: cmd.op = OP_DIV_BB;
      ST_PB_WAIT: if (sts.div_done) cmd.op = OP_B_SQ;
      ST_M_START: cmd.op = OP_DIV_FA;
      ST_M_WAIT:  if (sts.div_done) cmd.op = OP_ANS_ADD;
      ST_NEXT: begin
        if (!last_r) cmd.op = second_r ? OP_J_NEXT : OP_D_QJ;
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      last_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

[rtl/necklace_count_mod_p_top.sv]
// Run time is data dependent: a zero length or a modulus of at most one goes
// straight from the check to the result. Every divide runs on one shared
// divider: each divisor trial, each totient step and each exponent bit of the
// square-and-multiply waits on it, plus a second divide when the bit is set.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is delivered. Reset: synchronous active-low rst_n returns to idle.
// ----------------------------------------------------------------------------
// necklace_count_mod_p_top
// Counts n-bead, n-color necklaces under rotation modulo p.
// ----------------------------------------------------------------------------
module necklace_count_mod_p_top
  import ncp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ncp_in_if.sink    in_if,
  ncp_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  ncp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ncp_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .in_n  (in_if.necklace_length),
    .in_p  (in_if.modulus),
    .sts   (sts),
    .ans   (out_if.count_mod_p)
  );

endmodule

[test/tb_necklace_count_mod_p_top.sv]
// ----------------------------------------------------------------------------
// tb_necklace_count_mod_p_top
// Self-checking bench for the rotation necklace counter. A queue-fed driver
// sends (length, modulus) requests with random gaps. A stalling monitor
// compares each count with a behavioral necklace count computed at request
// acceptance.
// ----------------------------------------------------------------------------
module tb_necklace_count_mod_p_top;

  typedef struct {
    logic [31:0] length;
    logic [15:0] modulus;
  } request_t;

  logic clk;
  logic rst_n;

  ncp_in_if  in_ch ();
  ncp_out_if out_ch ();

  necklace_count_mod_p_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  request_t          pending_requests[$];
  logic [15:0]       expected_counts[$];
  int unsigned       mismatch_count = 0;
  int unsigned       accepted_count = 0;
  int unsigned       result_count = 0;
  int unsigned       send_gap;
  int unsigned       recv_stall;
  longint unsigned   cycle_count = 0;

  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Euler totient by plain trial division
  function automatic longint unsigned euler_phi(longint unsigned v);
    longint unsigned s;
    longint unsigned q;
    s = v;
    q = 2;
    while (q * q <= v) begin
      if (v % q == 0) begin
        s = s / q * (q - 1);
        while (v % q == 0) v = v / q;
      end
      q++;
    end
    if (v > 1) s = s / v * (v - 1);
    return s;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      e = e >> 1;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  function automatic longint unsigned divisor_term(longint unsigned n, longint unsigned d,
                                                   longint unsigned m);
    return ((euler_phi(d) % m) * pow_mod(n, n / d - 1, m)) % m;
  endfunction

  // Necklace count under rotation, reduced mod p
  function automatic logic [15:0] necklace_count(logic [31:0] len, logic [15:0] modv);
    longint unsigned n;
    longint unsigned m;
    longint unsigned j;
    longint unsigned sum;
    n = len;
    m = modv;
    sum = 0;
    if (n == 0 || m == 0) return 16'd0;
    j = 1;
    while (j * j < n) begin
      if (n % j == 0) begin
        sum = (sum + divisor_term(n, j, m)) % m;
        sum = (sum + divisor_term(n, n / j, m)) % m;
      end
      j++;
    end
    if (j * j == n) sum = (sum + divisor_term(n, j, m)) % m;
    return sum[15:0];
  endfunction

  // Gap drawn per item; quiet stretches run with no idling
  function automatic int unsigned draw_gap(int unsigned seq);
    if ((seq / 12) % 3 == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             result_count);
    mismatch_count++;
  endtask

  // Driver: advance through pending requests, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.necklace_length <= '0;
      in_ch.modulus         <= '0;
      send_gap              <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_counts.push_back(necklace_count(in_ch.necklace_length, in_ch.modulus));
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          request_t r;
          r = pending_requests.pop_front();
          in_ch.necklace_length <= r.length;
          in_ch.modulus         <= r.modulus;
          in_ch.valid           <= 1'b1;
          send_gap              <= draw_gap(accepted_count + 5);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each count against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      int unsigned stall;
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected count", out_ch.count_mod_p, 16'd0);
      end else begin
        logic [15:0] want;
        want = expected_counts.pop_front();
        if (out_ch.count_mod_p !== want)
          report_mismatch("count_mod_p", out_ch.count_mod_p, want);
      end
      result_count++;
      stall        = draw_gap(result_count + 1);
      recv_stall   <= stall;
      out_ch.ready <= (stall == 0) ? 1'b1 : 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall   <= recv_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_necklace_count_mod_p_top: done, errors");
      $finish;
    end
  end

  task automatic add_request(input logic [31:0] len, input logic [15:0] modv);
    request_t r;
    r.length  = len;
    r.modulus = modv;
    pending_requests.push_back(r);
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned total;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, modulus one, out-of-range zeros, squares, primes
    add_request(32'd1, 16'd65535);
    add_request(32'd1, 16'd1);
    add_request(32'd12, 16'd1);
    add_request(32'd0, 16'd1000);
    add_request(32'd10, 16'd0);
    add_request(32'd0, 16'd0);
    add_request(32'd2, 16'd65535);
    add_request(32'd4, 16'd9973);
    add_request(32'd9, 16'd65521);
    add_request(32'd36, 16'd32768);
    add_request(32'd97, 16'd1000);
    add_request(32'd360, 16'd2);
    add_request(32'd4096, 16'd65535);
    add_request(32'd65537, 16'd43690);
    add_request(32'd1000000, 16'd21845);
    add_request(32'd999983, 16'd12345);
    add_request(32'hFFFF_FFFF, 16'd65535);

    // Random: mostly small lengths, a few mid-size, random moduli
    for (int i = 0; i < 83; i++) begin
      logic [31:0] len;
      logic [15:0] modv;
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 1000000);
        1, 2: len = $urandom_range(1, 64);
        default: len = $urandom_range(1, 5000);
      endcase
      case ($urandom_range(0, 9))
        0: modv = 16'($urandom_range(1, 3));
        1: modv = 16'd65535 - 16'($urandom_range(0, 40));
        default: modv = 16'($urandom_range(1, 65535));
      endcase
      add_request(len, modv);
    end
    total = pending_requests.size();

    wait (accepted_count == total && expected_counts.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_necklace_count_mod_p_top: done, clean");
    else
      $display("tb_necklace_count_mod_p_top: done, errors");
    $finish;
  end

endmodule
